[hdl/f4st_pkg.sv]
// ----------------------------------------------------------------------------
// f4st_pkg: shared types and constants of the F4 DCT stego codec
// item layouts, request codes, register indexes and fixed limits
// ----------------------------------------------------------------------------
package f4st_pkg;

	localparam int MSG_BYTES_DEF = 1024;

	// request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_COEF  = 2'd2;
	localparam logic [1:0] REQ_END   = 2'd3;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 1'd1;

	localparam logic [5:0]  LAST_POS    = 6'd63;
	localparam logic [13:0] BIT_CNT_MAX = 14'h3fff;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [9:0]         msg_index;
		logic [7:0]         msg_byte;
		logic signed [15:0] coef_value;
		logic [5:0]         coef_position;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] coef_out;
		logic               byte_valid;
		logic [7:0]         byte_out;
		logic [9:0]         byte_index;
		logic               is_end;
		logic               all_embedded;
	} out_item_t;

endpackage

[hdl/f4_dct_stego_codec_unit.sv]
// ----------------------------------------------------------------------------
// f4_dct_stego_codec_unit: F4 embed / extract over quantized DCT coefficients
// top level: configuration registers, input register, core and result buffer
// ----------------------------------------------------------------------------
// Feed coefficients in block order, one item each, after a start image item;
// message bytes are loaded beforehand with load items. Each item is held in
// the input register, the core computes its result and updates state while it
// is held there, and the result is written into a two-entry buffer, so a
// coefficient can enter on every clock while in_stall is low; its result then
// reaches the output from the buffer entry. Input stall rises only when the
// result buffer is full, i.e. when the downstream side holds results back. The
// message byte in use is held in a register and the following byte is read
// from the buffer memory ahead of time, so crossing a byte boundary causes no
// stall. No clearing pass follows reset. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module f4_dct_stego_codec_unit
	import f4st_pkg::*;
#(
	parameter int MSG_BYTES = MSG_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input item channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	// result item channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic        mode_q;
	logic [10:0] msg_len_q;

	in_item_t    item_s1;
	logic        valid_s1;
	logic        needs_res;
	logic        go;
	logic        fire;
	logic        can_push;
	out_item_t   res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			msg_len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:    mode_q    <= cfg_data[0];
				CFG_MSG_LEN: msg_len_q <= cfg_data;
			endcase
		end
	end

	// load and start items make no result, so they never wait on the buffer
	assign needs_res = (item_s1.req_type == REQ_COEF) || (item_s1.req_type == REQ_END);
	assign go        = !needs_res || can_push;
	assign fire      = valid_s1 && go;
	assign in_stall  = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// state and per-item logic
	f4st_core #(
		.MSG_BYTES (MSG_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.mode    (mode_q),
		.msg_len (msg_len_q),
		.res     (res)
	);

	// result buffer
	f4st_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && needs_res),
		.push_item (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

[hdl/f4st_msg_mem.sv]
// ----------------------------------------------------------------------------
// f4st_msg_mem: message byte buffer
// one write port, one registered read port, write data forwarded on a hit
// ----------------------------------------------------------------------------
module f4st_msg_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/f4st_out_queue.sv]
// ----------------------------------------------------------------------------
// f4st_out_queue: two-entry result buffer
// decouples the result stall from the input side
// ----------------------------------------------------------------------------
module f4st_out_queue
	import f4st_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      can_push,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	out_item_t  ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign can_push  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = ent_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/f4st_core.sv]
// ----------------------------------------------------------------------------
// f4st_core: per-item embed / extract logic and codec state
// bit counter, byte assembly and the current message byte with its prefetch
// ----------------------------------------------------------------------------
module f4st_core
	import f4st_pkg::*;
#(
	parameter int MSG_BYTES = MSG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_item_t   item,
	input  logic       mode,
	input  logic [10:0] msg_len,
	output out_item_t  res
);

	localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
	localparam logic [10:0] LEN_CAP = (MSG_BYTES > 2047) ? 11'd2047 : 11'(MSG_BYTES);
	localparam logic [16:0] DEPTH17 = 17'(MSG_BYTES);

	logic [13:0] bit_cnt_q;
	logic [7:0]  part_q;
	logic [7:0]  cur_q;
	logic [7:0]  byte0_q;

	logic [10:0] len_eff;
	logic [13:0] bit_lim;
	logic [10:0] bidx;
	logic [2:0]  bpos;
	logic        msg_left;
	logic        in_msg;

	logic [16:0] rd_wide;
	logic [16:0] wr_wide;
	logic [AW-1:0] rd_addr;
	logic        wr_ok;
	logic        mem_we;
	logic [7:0]  rdata;

	logic        is_coef;
	logic signed [15:0] v;
	logic signed [15:0] step;
	logic signed [15:0] v_step;
	logic        neg;
	logic        carrier;
	logic        msg_bit;
	logic        flip;
	logic        sat;
	logic [13:0] bit_inc;
	logic        cnt_en;
	logic        adv;
	logic        carried;
	logic [7:0]  part_n;
	logic        done_byte;

	assign len_eff  = (msg_len > LEN_CAP) ? LEN_CAP : msg_len;
	assign bit_lim  = {len_eff, 3'b000};
	assign bidx     = bit_cnt_q[13:3];
	assign bpos     = 3'd7 - bit_cnt_q[2:0];
	assign msg_left = (bit_cnt_q < bit_lim);
	assign in_msg   = (bidx < len_eff);

	// buffer reads the byte after the current one, or address 0 past its depth
	assign rd_wide = 17'(bidx) + 17'd1;
	assign rd_addr = (rd_wide < DEPTH17) ? rd_wide[AW-1:0] : '0;
	assign wr_wide = 17'(item.msg_index);
	assign wr_ok   = (wr_wide < DEPTH17);
	assign mem_we  = fire && (item.req_type == REQ_LOAD) && wr_ok;

	f4st_msg_mem #(
		.DEPTH (MSG_BYTES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_wide[AW-1:0]),
		.wdata (item.msg_byte),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign is_coef = (item.req_type == REQ_COEF);
	assign v       = item.coef_value;
	assign neg     = v[15];
	assign carrier = (v != 16'sd0) && (item.coef_position != LAST_POS);
	assign step    = neg ? 16'sd1 : -16'sd1;
	assign v_step  = v + step;
	assign msg_bit = cur_q[bpos];
	assign flip    = neg ? (v[0] == msg_bit) : (v[0] != msg_bit);
	assign sat     = (bit_cnt_q == BIT_CNT_MAX);
	assign bit_inc = bit_cnt_q + 14'd1;
	assign carried = v[0] ^ neg;

	always_comb begin
		cnt_en    = 1'b0;
		done_byte = 1'b0;
		part_n    = part_q;
		res       = '0;
		case (item.req_type)
			REQ_COEF: begin
				res.coef_out = v;
				if (carrier) begin
					if (mode) begin
						if (msg_left) begin
							if (flip) begin
								res.coef_out = v_step;
							end
							// a carrier that shrinks to zero keeps the bit pending
							cnt_en = !(flip && (v_step == 16'sd0));
						end
					end else begin
						if (in_msg) begin
							part_n[bpos] = part_q[bpos] | carried;
						end
						cnt_en    = !sat;
						done_byte = !sat && (bit_inc[2:0] == 3'd0) && in_msg;
						if (done_byte) begin
							res.byte_valid = 1'b1;
							res.byte_out   = part_n;
							res.byte_index = bidx[9:0];
						end
					end
				end
			end
			REQ_END: begin
				res.is_end = 1'b1;
				if (mode) begin
					res.all_embedded = !msg_left;
				end else if ((bit_cnt_q[2:0] != 3'd0) && in_msg) begin
					res.byte_valid = 1'b1;
					res.byte_out   = part_q;
					res.byte_index = bidx[9:0];
				end
			end
			default: ;
		endcase
	end

	assign adv = cnt_en && (bit_cnt_q[2:0] == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			part_q    <= '0;
		end else if (fire) begin
			if (item.req_type == REQ_START) begin
				bit_cnt_q <= '0;
				part_q    <= '0;
			end else if (is_coef && carrier) begin
				if (cnt_en) begin
					bit_cnt_q <= bit_inc;
				end
				if (!mode) begin
					part_q <= done_byte ? 8'd0 : part_n;
				end
			end
		end
	end

	// current message byte, kept coherent with loads
	always_ff @(posedge clk) begin
		if (fire) begin
			case (item.req_type)
				REQ_LOAD: begin
					if (wr_ok && (wr_wide == 17'(bidx))) begin
						cur_q <= item.msg_byte;
					end
					if (item.msg_index == 10'd0) begin
						byte0_q <= item.msg_byte;
					end
				end
				REQ_START: cur_q <= byte0_q;
				REQ_COEF: begin
					if (adv) begin
						cur_q <= rdata;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[hdl/f4st_checker.sv]
// ----------------------------------------------------------------------------
// f4st_checker: port-level checks of the F4 DCT stego codec
// bound to the top level
// ----------------------------------------------------------------------------
module f4st_checker
	import f4st_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input in_item_t             in_item,
	input logic                 out_valid,
	input logic                 out_stall,
	input out_item_t            out_item
);

	// a stalled input item stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_item))
		else $error("stalled input item changed or dropped");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("stalled result changed");

	// input backpressure only comes while results are pending in the result buffer
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && $past(out_valid))
		else $error("input stalled without pending results");

	// unused result fields read as zero
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_item.is_end || out_item.coef_out == 16'sd0) &&
			(out_item.is_end || !out_item.all_embedded) &&
			(out_item.byte_valid ||
				(out_item.byte_out == 8'd0 && out_item.byte_index == 10'd0)))
		else $error("unused result field not zero");

endmodule

bind f4_dct_stego_codec_unit f4st_checker u_f4st_checker (.*);
